[rtl/core/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication into the next cycle, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/brr_pkg.sv]
// Package for the bit string rank/unrank block: item type, codes and binomial rows.
// Depends on nothing; used by brr_cell and bit_string_rank_unrank.
package brr_pkg;

	localparam logic CMD_RANK   = 1'b0;
	localparam logic CMD_UNRANK = 1'b1;

	localparam logic CFG_NUM_BITS     = 1'b0;
	localparam logic CFG_NUM_OCCUPIED = 1'b1;

	localparam logic [4:0] NUM_BITS_RST     = 5'd16;
	localparam logic [4:0] NUM_OCCUPIED_RST = 5'd8;

	// Binomials are clipped here; valid addresses never reach this value.
	localparam logic [13:0] BINOM_SAT = 14'h3FFF;

	typedef logic [31:0][13:0] binom_row_t;

	typedef struct packed {
		logic        cmd;
		logic        zero_addr;
		logic [15:0] bits;
		logic [15:0] acc;
		logic [4:0]  cnt;
	} brr_item_t;

	// Row n of Pascal's triangle, clipped, for k = 0 .. 31.
	function automatic binom_row_t binom_row(input int unsigned n);
		binom_row_t  row;
		logic [14:0] s;
		row    = '0;
		row[0] = 14'd1;
		for (int unsigned m = 1; m <= n; m++) begin
			for (int k = 31; k >= 1; k--) begin
				s = {1'b0, row[k]} + {1'b0, row[k-1]};
				row[k] = (s > {1'b0, BINOM_SAT}) ? BINOM_SAT : s[13:0];
			end
		end
		return row;
	endfunction

endpackage

[rtl/core/brr_cell.sv]
// One cell of the rank/unrank chain: handles one rank position and one unrank position.
// Depends on brr_pkg for the item type and the binomial rows.
module brr_cell
	import brr_pkg::*;
#(
	parameter int RANK_POS   = 0,
	parameter int UNRANK_POS = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [4:0] n_eff,
	input  logic      in_valid,
	output logic      in_ready,
	input  brr_item_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output brr_item_t out_data
);

	localparam binom_row_t RANK_ROW   = binom_row(RANK_POS);
	localparam binom_row_t UNRANK_ROW = binom_row(UNRANK_POS);
	localparam logic [4:0] RANK_POS_W   = 5'(RANK_POS);
	localparam logic [4:0] UNRANK_POS_W = 5'(UNRANK_POS);
	localparam logic       RANK_LIVE    = (RANK_POS < 16);
	localparam logic       UNRANK_LIVE  = (UNRANK_POS < 16);
	localparam logic [3:0] RANK_IDX     = 4'(RANK_POS < 16 ? RANK_POS : 0);
	localparam logic [3:0] UNRANK_IDX   = 4'(UNRANK_POS < 16 ? UNRANK_POS : 0);

	logic        vld_q;
	brr_item_t   data_q;
	brr_item_t   nxt;
	logic [4:0]  cnt_inc;
	logic [13:0] b_rank;
	logic [13:0] b_unrank;

	assign cnt_inc  = in_data.cnt + 5'd1;
	assign b_rank   = RANK_ROW[cnt_inc];
	assign b_unrank = UNRANK_ROW[in_data.cnt];

	always_comb begin
		nxt = in_data;
		case (in_data.cmd)
			CMD_RANK: begin
				if (RANK_LIVE && (n_eff > RANK_POS_W) && in_data.bits[RANK_IDX]) begin
					nxt.cnt = cnt_inc;
					nxt.acc = in_data.acc + {2'b00, b_rank};
				end
			end
			CMD_UNRANK: begin
				if ((n_eff > UNRANK_POS_W) && (in_data.cnt != 5'd0) &&
				    (in_data.acc >= {2'b00, b_unrank})) begin
					if (UNRANK_LIVE) begin
						nxt.bits[UNRANK_IDX] = 1'b1;
					end
					nxt.acc = in_data.acc - {2'b00, b_unrank};
					nxt.cnt = in_data.cnt - 5'd1;
				end
			end
			default: nxt = in_data;
		endcase
	end

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

endmodule

[rtl/core/bit_string_rank_unrank.sv]
// Top level of the bit string rank/unrank block: configuration, chain of cells, output register.
// Depends on brr_pkg and brr_cell.
//
//   channel | direction | handshake         | contents
//   s_*     | in        | s_tvalid/s_tready | tdata: bit_string, address; tuser: command
//   m_*     | out       | m_tvalid/m_tready | tdata: value; tuser: out_of_range
//   cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle is taken while the chain is not stalled; each item passes MAX_BITS
// cells, one bit position per cell, and then the output register. The first cell loads
// at the accepting edge; the result is held in the output register after the last cell.
// Reset clears all valid bits and sets num_bits to 16 and num_occupied to 8.
// A stalled output holds its item; empty cells ahead of it still fill, so bubbles close up.
module bit_string_rank_unrank
	import brr_pkg::*;
#(
	parameter int MAX_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // bit_string [15:0], address [29:16], zero padding
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // value [15:0]
	output logic        m_tuser,   // out_of_range
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	logic [4:0] num_bits_q;
	logic [4:0] num_occupied_q;
	logic [4:0] n_eff;

	logic      link_vld [MAX_BITS+1];
	logic      link_rdy [MAX_BITS+1];
	brr_item_t link_dat [MAX_BITS+1];

	brr_item_t   entry;
	logic [15:0] bit_string;
	logic [13:0] address;
	brr_item_t   last;
	logic        bad;

	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic        m_tuser_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bits_q     <= NUM_BITS_RST;
			num_occupied_q <= NUM_OCCUPIED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NUM_BITS:     num_bits_q     <= cfg_data;
				CFG_NUM_OCCUPIED: num_occupied_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff = (num_bits_q > 5'(MAX_BITS)) ? 5'(MAX_BITS) : num_bits_q;

	assign bit_string = s_tdata[15:0];
	assign address    = s_tdata[29:16];

	always_comb begin
		entry.cmd       = s_tuser;
		entry.zero_addr = (address == 14'd0);
		if (s_tuser == CMD_UNRANK) begin
			entry.bits = 16'd0;
			entry.acc  = {2'b00, address} - 16'd1;
			entry.cnt  = num_occupied_q;
		end else begin
			entry.bits = bit_string;
			entry.acc  = 16'd0;
			entry.cnt  = 5'd0;
		end
	end

	assign link_vld[0] = s_tvalid;
	assign s_tready    = link_rdy[0];
	assign link_dat[0] = entry;

	for (genvar c = 0; c < MAX_BITS; c++) begin : g_cell
		brr_cell #(
			.RANK_POS   (c),
			.UNRANK_POS (MAX_BITS - 1 - c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.n_eff     (n_eff),
			.in_valid  (link_vld[c]),
			.in_ready  (link_rdy[c]),
			.in_data   (link_dat[c]),
			.out_valid (link_vld[c+1]),
			.out_ready (link_rdy[c+1]),
			.out_data  (link_dat[c+1])
		);
	end

	assign last = link_dat[MAX_BITS];
	assign bad  = last.zero_addr || (last.cnt != 5'd0) || (last.acc != 16'd0);
	assign link_rdy[MAX_BITS] = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (link_vld[MAX_BITS] && link_rdy[MAX_BITS]) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (link_vld[MAX_BITS] && link_rdy[MAX_BITS]) begin
			if (last.cmd == CMD_UNRANK) begin
				m_tdata_q <= bad ? 16'd0 : last.bits;
				m_tuser_q <= bad;
			end else begin
				m_tdata_q <= last.acc + 16'd1;
				m_tuser_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[rtl/core/brr_checker.sv]
// Port-level checker for bit_string_rank_unrank, attached by the bind at the end.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module brr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	logic [7:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 8'd0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 8'd1;
		end
	end

	`ASSERT_NEXT(a_out_valid_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`ASSERT_NEXT(a_out_data_holds, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_SAME(a_no_invented_item, clk, arst_n, m_tvalid, pending_q != 8'd0)
	`ASSERT_SAME(a_range_value_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 16'd0)

endmodule

bind bit_string_rank_unrank brr_checker u_brr_checker (.*);

[sim/tb_bit_string_rank_unrank.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bit_string_rank_unrank: rank and unrank lookups under several
// widths and set-bit counts, checked against a predictor of the addressing scheme.
// Depends on brr_pkg and the bit_string_rank_unrank top level.
module tb_bit_string_rank_unrank;
	import brr_pkg::*;

	localparam int MAX_BITS  = 16;
	localparam int LONG_HOLD = 120;

	typedef struct packed {
		logic        cmd;
		logic [15:0] bits;
		logic [13:0] addr;
	} lookup_t;

	typedef struct packed {
		logic [15:0] value;
		logic        oor;
	} result_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_THIRDS} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // bit_string [15:0], address [29:16], zero padding
	logic        s_tuser = 1'b0; // command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // value [15:0]
	logic        m_tuser;        // out_of_range
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_NUM_BITS;
	logic [4:0]  cfg_data = '0;

	lookup_t     pending_lookups[$];
	result_t     pending_results[$];
	logic [4:0]  width_reg = NUM_BITS_RST;
	logic [4:0]  occupied_reg = NUM_OCCUPIED_RST;
	int          mismatches = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_req = 0;
	int          holds_done = 0;
	int          hold_left = 0;
	int          mode_left = 0;
	rx_mode_t    ready_mode = RX_OPEN;
	int unsigned rx_cycle = 0;

	bit_string_rank_unrank #(.MAX_BITS(MAX_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned choose(int unsigned n, int unsigned k);
		longint unsigned c;
		int unsigned     m;
		int unsigned     i;
		c = 1;
		if (k > n) return 0;
		m = (k > n - k) ? n - k : k;
		for (i = 0; i < m; i++)
			c = c * (n - i) / (i + 1);
		return c;
	endfunction

	function automatic int unsigned eff_width();
		return (width_reg > MAX_BITS) ? MAX_BITS : width_reg;
	endfunction

	function automatic result_t lookup_result(lookup_t it);
		result_t         r;
		int              n;
		int              p;
		int unsigned     ones;
		int unsigned     left;
		longint unsigned sum;
		longint unsigned rem;
		longint unsigned total;
		longint unsigned b;
		r = '0;
		n = eff_width();
		if (it.cmd == CMD_RANK) begin
			sum  = 0;
			ones = 0;
			for (p = 0; p < n; p++) begin
				if (it.bits[p]) begin
					ones++;
					sum += choose(p, ones);
				end
			end
			r.value = 16'(sum + 1);
		end else begin
			total = choose(n, occupied_reg);
			if (it.addr == 0 || it.addr > total) begin
				r.oor = 1'b1;
			end else begin
				rem  = it.addr - 1;
				left = occupied_reg;
				for (p = n - 1; p >= 0; p--) begin
					if (left > 0) begin
						b = choose(p, left);
						if (rem >= b) begin
							r.value[p] = 1'b1;
							rem -= b;
							left--;
						end
					end
				end
			end
		end
		return r;
	endfunction

	// Sender: items leave the queue in bursts separated by random gaps.
	always @(posedge clk) begin
		logic    offer;
		lookup_t head;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				head = pending_lookups.pop_front();
			if (!s_tvalid || s_tready) begin
				offer = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_lookups.size() != 0) begin
					offer = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= offer;
				if (offer) begin
					head = pending_lookups[0];
					s_tdata <= {2'b00, head.addr, head.bits};
					s_tuser <= head.cmd;
				end
			end
		end
	end

	// Receiver: a changing stall pattern, plus long hold-offs on request.
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req != holds_done) begin
				holds_done++;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					ready_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (ready_mode)
					RX_OPEN: m_tready <= 1'b1;
					RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= (rx_cycle % 3 != 0);
				endcase
			end
		end
	end

	// Monitor: predicts at input acceptance, checks at output acceptance.
	always @(posedge clk) begin
		lookup_t it;
		result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				it.cmd  = s_tuser;
				it.bits = s_tdata[15:0];
				it.addr = s_tdata[29:16];
				pending_results.push_back(lookup_result(it));
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result value %h out_of_range %b",
						$time, m_tdata, m_tuser);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.value) begin
						mismatches++;
						$display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
					end
					if (m_tuser !== want.oor) begin
						mismatches++;
						$display("%0t: out_of_range expected %b actual %b",
							$time, want.oor, m_tuser);
					end
				end
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [4:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_NUM_BITS)
			width_reg = val;
		else
			occupied_reg = val;
	endtask

	task automatic drain();
		while (pending_lookups.size() != 0 || pending_results.size() != 0)
			@(negedge clk);
		repeat (MAX_BITS + 4) @(posedge clk);
	endtask

	task automatic set_shape(input logic [4:0] nb, input logic [4:0] no);
		drain();
		write_reg(CFG_NUM_BITS, nb);
		write_reg(CFG_NUM_OCCUPIED, no);
	endtask

	task automatic add_lookup(input logic cmd, input logic [15:0] bits, input logic [13:0] addr);
		lookup_t it;
		it.cmd  = cmd;
		it.bits = bits;
		it.addr = addr;
		pending_lookups.push_back(it);
	endtask

	// Rank lookups and mostly valid unrank addresses for the current shape, with boundary and noise cases mixed in.
	task automatic add_random_lookups(input int count);
		longint unsigned total;
		int unsigned     pick;
		logic [13:0]     addr;
		total = choose(eff_width(), occupied_reg);
		repeat (count) begin
			pick = $urandom_range(0, 9);
			addr = 14'($urandom_range(0, 16383));
			if (pick >= 3 && pick < 8 && total != 0) begin
				addr = 14'($urandom_range(1, int'(total)));
			end else if (pick == 8) begin
				case ($urandom_range(0, 2))
					0: addr = 14'd0;
					1: addr = 14'(total);
					default: addr = 14'(total + 1);
				endcase
			end
			add_lookup((pick < 3) ? CMD_RANK : CMD_UNRANK, 16'($urandom), addr);
		end
	endtask

	initial begin
		int          ph;
		logic [4:0]  nb;
		logic [4:0]  no;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset shape: sixteen positions, eight set bits.
		add_lookup(CMD_RANK, 16'h0000, 14'd0);
		add_lookup(CMD_RANK, 16'hFFFF, 14'h3FFF);
		add_lookup(CMD_RANK, 16'h00FF, 14'd5);
		add_lookup(CMD_RANK, 16'hFF00, 14'd0);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd0);
		add_lookup(CMD_UNRANK, 16'hFFFF, 14'd1);
		add_lookup(CMD_UNRANK, 16'h1234, 14'd12870);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd12871);
		add_lookup(CMD_UNRANK, 16'h0000, 14'h3FFF);

		// Zero width accepts only address one with nothing set.
		set_shape(5'd0, 5'd0);
		add_lookup(CMD_RANK, 16'hFFFF, 14'd0);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd1);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd2);

		// Width above the limit, and more set bits than positions.
		set_shape(5'd31, 5'd31);
		add_lookup(CMD_RANK, 16'hFFFF, 14'd0);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd1);
		set_shape(5'd31, 5'd16);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd1);
		add_lookup(CMD_UNRANK, 16'h0000, 14'd2);

		// Narrow width: string bits above the width are not counted.
		set_shape(5'd3, 5'd1);
		add_lookup(CMD_RANK, 16'h8001, 14'd0);
		add_lookup(CMD_UNRANK, 16'hFFFF, 14'd3);
		add_lookup(CMD_UNRANK, 16'hFFFF, 14'd4);

		for (ph = 0; ph < 14; ph++) begin
			case (ph)
				0: begin nb = 5'd1;  no = 5'd0;  end
				1: begin nb = 5'd1;  no = 5'd1;  end
				2: begin nb = 5'd12; no = 5'd6;  end
				3: begin nb = 5'd16; no = 5'd16; end
				4: begin nb = 5'd16; no = 5'd0;  end
				5: begin nb = 5'd20; no = 5'd5;  end
				default: begin
					nb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
						: 5'($urandom_range(1, 16));
					if ($urandom_range(0, 7) == 0)
						no = 5'($urandom_range(0, 31));
					else
						no = 5'($urandom_range(0, (nb > 16) ? 16 : nb));
				end
			endcase
			set_shape(nb, no);
			if (ph == 2)
				hold_req++;
			add_random_lookups(38);
		end

		while (pending_lookups.size() != 0 || pending_results.size() != 0)
			@(negedge clk);
		repeat (MAX_BITS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("tb_bit_string_rank_unrank: PASS");
		else
			$display("tb_bit_string_rank_unrank: FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_bit_string_rank_unrank: FAIL");
		$finish;
	end

endmodule
